// File: rtl/core/lgg_pkg.sv
package lgg_pkg;

  // Default lattice depth
  localparam int MAX_SITES_DEF = 1024;

  localparam int SITE_W = 11;
  localparam int RND_W  = 16;
  localparam int W_W    = 20;   // weight width, exp(127/16)*256 < 2^20
  localparam int TOT_W  = 21;   // w0 + w1 + w2
  localparam int PROD_W = RND_W + TOT_W;

  // Stages that may hold a lattice write not yet committed
  localparam int PEND_STAGES = 4;

  localparam logic [SITE_W-1:0] LEN_RESET = 11'd1024;
  localparam logic [W_W-1:0]    W_EMPTY   = 20'd256;

  // Site contents
  localparam logic [1:0] SPC_EMPTY  = 2'd0;
  localparam logic [1:0] SPC_FIRST  = 2'd1;
  localparam logic [1:0] SPC_SECOND = 2'd2;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_BIAS_FIRST     = 3'd0,
    REG_BIAS_SECOND    = 3'd1,
    REG_COUP_FF        = 3'd2,
    REG_COUP_FS        = 3'd3,
    REG_COUP_SF        = 3'd4,
    REG_COUP_SS        = 3'd5,
    REG_LATTICE_LENGTH = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] bias_first;
    logic [7:0] bias_second;
    logic [7:0] coup_ff;
    logic [7:0] coup_fs;
    logic [7:0] coup_sf;
    logic [7:0] coup_ss;
  } cfg_t;

  // Item as it enters the pipeline
  typedef struct packed {
    logic              upd;    // gibbs update
    logic              wr;     // direct write
    logic              oor;    // site outside the lattice
    logic              mw;     // commits a lattice write
    logic              lo_ok;  // left neighbour in range
    logic              hi_ok;  // right neighbour in range
    logic [SITE_W-1:0] site;
    logic [1:0]        spin;
    logic [RND_W-1:0]  rnd;
  } item_t;

  // Item state past the first stage
  typedef struct packed {
    logic              upd;
    logic              oor;
    logic              mw;
    logic [SITE_W-1:0] site;
    logic [1:0]        spc;
    logic [RND_W-1:0]  rnd;
  } st_t;

  typedef struct packed {
    logic              act;
    logic [SITE_W-1:0] site;
  } pend_t;

  typedef struct packed {
    logic              en;
    logic [SITE_W-1:0] site;
    logic [1:0]        spc;
  } mem_wr_t;

  typedef logic [255:0][W_W-1:0] weight_lut_t;

  // Restoring long division; only used while the weight table is built
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(exp(E/16)*256) for every Q4.4 energy, built with the same Q14.50
  // truncation as the golden arithmetic. Evaluated at elaboration.
  function automatic weight_lut_t build_weight_lut();
    weight_lut_t        lut;
    logic [63:0]        pw [8];
    logic [63:0]        term;
    logic [63:0]        sum;
    logic [63:0]        p;
    logic [63:0]        q;
    logic [127:0]       prod;
    logic [7:0]         ib;
    logic signed [8:0]  e;
    logic [7:0]         mag;
    lut  = '0;
    term = 64'd1 << 50;
    sum  = 64'd1 << 50;
    for (int n = 1; n <= 20; n++) begin
      term = udiv64(term >> 4, 64'(n));
      sum  = sum + term;
    end
    pw[0] = sum;
    for (int k = 1; k < 8; k++) begin
      prod  = {64'd0, pw[k-1]} * {64'd0, pw[k-1]};
      pw[k] = prod[113:50];
    end
    for (int i = 0; i < 256; i++) begin
      ib  = 8'(i);
      e   = {ib[7], ib};
      mag = e[8] ? 8'(9'sd0 - e) : ib;
      p   = 64'd1 << 50;
      for (int k = 0; k < 8; k++) begin
        if (mag[k]) begin
          prod = {64'd0, p} * {64'd0, pw[k]};
          p    = prod[113:50];
        end
      end
      if (!e[8]) begin
        q = (p + (64'd1 << 41)) >> 42;
      end else begin
        q = udiv64((64'd1 << 58) + (p >> 1), p);
      end
      lut[i] = q[W_W-1:0];
    end
    return lut;
  endfunction

  localparam weight_lut_t WEIGHT_LUT = build_weight_lut();

endpackage

// File: rtl/core/lattice_gas_gibbs_site_update.sv
// Pipeline: five register stages (s1, s2, s3, s4 and the result register) from the input transfer to out_tvalid.
// Throughput: one item per cycle while the result stream is not stalled and sites are
//   two or more apart; an update or read next to (or at) a site whose write is still in
//   the 4-stage pipeline waits until that write lands in the lattice RAM.
// Reset: synchronous, active low; afterwards a clearing pass writes all MAX_SITES
//   lattice RAM entries as empty with in_tready low. Config writes are taken throughout.
module lattice_gas_gibbs_site_update #(
  parameter int MAX_SITES = lgg_pkg::MAX_SITES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // site_index[10:0], species_in[12:11], random_fraction[28:13]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // site_index_out[10:0], species_out[12:11]
  output logic [0:0]  out_tuser   // status[0]
);
  import lgg_pkg::*;

  localparam int AW = $clog2(MAX_SITES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t              cfg_r;
  logic [SITE_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      len_r <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_BIAS_FIRST:     cfg_r.bias_first  <= cfg_data[7:0];
        REG_BIAS_SECOND:    cfg_r.bias_second <= cfg_data[7:0];
        REG_COUP_FF:        cfg_r.coup_ff     <= cfg_data[7:0];
        REG_COUP_FS:        cfg_r.coup_fs     <= cfg_data[7:0];
        REG_COUP_SF:        cfg_r.coup_sf     <= cfg_data[7:0];
        REG_COUP_SS:        cfg_r.coup_ss     <= cfg_data[7:0];
        REG_LATTICE_LENGTH: len_r             <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset: one RAM entry per cycle
  // ---------------------------------------------------------------------------
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(MAX_SITES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic [SITE_W-1:0] site;
  op_e               op;
  logic              upd, wr, rd;
  logic              in_range, lo_ok, hi_ok, needs_read;
  item_t             item;

  assign site = in_tdata[10:0];
  assign op   = op_e'(in_tuser);

  always_comb begin
    upd = 1'b0;
    wr  = 1'b0;
    rd  = 1'b0;
    unique case (op)
      OP_UPDATE: upd = 1'b1;
      OP_WRITE:  wr  = 1'b1;
      OP_READ:   rd  = 1'b1;
      default:   rd  = 1'b1;  // spare code reads
    endcase
  end

  // effective length is lattice_length capped at MAX_SITES
  assign in_range   = (site != '0) && (site <= len_r) && (32'(site) <= MAX_SITES);
  assign lo_ok      = site >= 11'd2;
  assign hi_ok      = (site < len_r) && (32'(site) < MAX_SITES);
  assign needs_read = in_range && (upd || rd);

  always_comb begin
    item.upd   = upd;
    item.wr    = wr;
    item.oor   = !in_range;
    item.mw    = in_range && (upd || wr);
    item.lo_ok = lo_ok;
    item.hi_ok = hi_ok;
    item.site  = site;
    item.spin  = in_tdata[12:11];
    item.rnd   = in_tdata[28:13];
  end

  // ---------------------------------------------------------------------------
  // Read-after-write hazard: hold an update or read whose sites overlap a write
  // still in flight. Writes commit in order, so write ops never wait.
  // ---------------------------------------------------------------------------
  pend_t [PEND_STAGES-1:0] pend;
  logic                    hazard;

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < PEND_STAGES; i++) begin
      if (pend[i].act && ((pend[i].site == site) ||
                          ({1'b0, pend[i].site} == {1'b0, site} + 12'd1) ||
                          ({1'b0, pend[i].site} + 12'd1 == {1'b0, site}))) begin
        hazard = 1'b1;
      end
    end
  end

  logic adv;
  logic in_xfer;

  assign in_tready = adv && !clearing_r && !(needs_read && hazard);
  assign in_xfer   = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Lattice RAM: port A reads the left neighbour (or the site itself for a
  // read), port B the right neighbour. Unused ports park at entry 0.
  // ---------------------------------------------------------------------------
  logic [SITE_W-1:0] a_site, b_site;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [1:0]        rd_a, rd_b;
  mem_wr_t           mem_wr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [1:0]        mem_wdata;

  always_comb begin
    a_site = '0;
    b_site = '0;
    if (needs_read && rd) begin
      a_site = site - 11'd1;
    end else if (needs_read && lo_ok) begin
      a_site = site - 11'd2;
    end
    if (needs_read && upd && hi_ok) begin
      b_site = site;
    end
  end

  assign raddr_a = AW'(a_site);
  assign raddr_b = AW'(b_site);

  assign mem_we    = clearing_r || mem_wr.en;
  assign mem_waddr = clearing_r ? clr_cnt_r : AW'(mem_wr.site - 11'd1);
  assign mem_wdata = clearing_r ? SPC_EMPTY : mem_wr.spc;

  lgg_site_mem #(
    .DEPTH (MAX_SITES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (in_xfer),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // ---------------------------------------------------------------------------
  // Update pipeline: energy, weight lookup, draw scaling, selection, result reg
  // ---------------------------------------------------------------------------
  logic              out_vld;
  logic [SITE_W-1:0] out_site;
  logic [1:0]        out_spc;
  logic              out_status;

  lgg_update_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_xfer),
    .in_item    (item),
    .cfg        (cfg_r),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .out_tready (out_tready),
    .adv        (adv),
    .pend       (pend),
    .mem_wr     (mem_wr),
    .out_vld    (out_vld),
    .out_site   (out_site),
    .out_spc    (out_spc),
    .out_status (out_status)
  );

  assign out_tvalid   = out_vld;
  assign out_tdata    = {3'b000, out_spc, out_site};
  assign out_tuser[0] = out_status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_xfer_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("input taken during clearing pass");

  a_oor_reads_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[12:11] == SPC_EMPTY))
    else $error("out-of-range result carries a species");

  a_species_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:11] == SPC_EMPTY || out_tdata[12:11] == SPC_FIRST ||
                    out_tdata[12:11] == SPC_SECOND))
    else $error("illegal species on result");

  a_write_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < MAX_SITES))
    else $error("lattice write beyond depth");

endmodule

// File: rtl/core/lgg_site_mem.sv
module lgg_site_mem #(
  parameter int DEPTH = lgg_pkg::MAX_SITES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [1:0]    rdata_a,
  output logic [1:0]    rdata_b
);
  import lgg_pkg::*;

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/core/lgg_update_pipe.sv
module lgg_update_pipe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  lgg_pkg::item_t                  in_item,
  input  lgg_pkg::cfg_t                   cfg,
  input  logic [1:0]                      rd_a,
  input  logic [1:0]                      rd_b,
  input  logic                            out_tready,
  output logic                            adv,
  output lgg_pkg::pend_t [lgg_pkg::PEND_STAGES-1:0] pend,
  output lgg_pkg::mem_wr_t                mem_wr,
  output logic                            out_vld,
  output logic [lgg_pkg::SITE_W-1:0]      out_site,
  output logic [1:0]                      out_spc,
  output logic                            out_status
);
  import lgg_pkg::*;

  // coupling contribution of one neighbour
  function automatic logic signed [9:0] nb_term(logic ok, logic [1:0] nb,
                                               logic [7:0] c_one, logic [7:0] c_two);
    logic signed [9:0] t;
    t = '0;
    if (ok && nb == SPC_FIRST) begin
      t = {{2{c_one[7]}}, c_one};
    end else if (ok && nb == SPC_SECOND) begin
      t = {{2{c_two[7]}}, c_two};
    end
    return t;
  endfunction

  function automatic logic [7:0] sat8(logic signed [9:0] v);
    logic [7:0] s;
    if (v > 10'sd127) begin
      s = 8'h7F;
    end else if (v < -10'sd128) begin
      s = 8'h80;
    end else begin
      s = v[7:0];
    end
    return s;
  endfunction

  logic              s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  item_t             s1_r;
  st_t               s2_r, s3_r, s4_r;
  logic [7:0]        e1_r, e2_r;
  logic [W_W-1:0]    w1_s3_r, w1_s4_r;
  logic [TOT_W-1:0]  tot_r;
  logic [TOT_W-1:0]  r_r;

  logic              out_vld_r, out_status_r;
  logic [SITE_W-1:0] out_site_r;
  logic [1:0]        out_spc_r;

  // stage 1: energies, direct write/read results
  logic signed [9:0] e1_sum, e2_sum;
  logic [1:0]        s1_spc;
  st_t               s1_st;

  always_comb begin
    e1_sum = {{2{cfg.bias_first[7]}}, cfg.bias_first}
           + nb_term(s1_r.lo_ok, rd_a, cfg.coup_ff, cfg.coup_fs)
           + nb_term(s1_r.hi_ok, rd_b, cfg.coup_ff, cfg.coup_fs);
    e2_sum = {{2{cfg.bias_second[7]}}, cfg.bias_second}
           + nb_term(s1_r.lo_ok, rd_a, cfg.coup_sf, cfg.coup_ss)
           + nb_term(s1_r.hi_ok, rd_b, cfg.coup_sf, cfg.coup_ss);
    priority if (s1_r.oor || s1_r.upd) begin
      s1_spc = SPC_EMPTY;
    end else if (s1_r.wr) begin
      s1_spc = (s1_r.spin == SPC_FIRST || s1_r.spin == SPC_SECOND) ? s1_r.spin
                                                                    : SPC_EMPTY;
    end else begin
      s1_spc = rd_a;
    end
    s1_st.upd  = s1_r.upd;
    s1_st.oor  = s1_r.oor;
    s1_st.mw   = s1_r.mw;
    s1_st.site = s1_r.site;
    s1_st.spc  = s1_spc;
    s1_st.rnd  = s1_r.rnd;
  end

  // stage 2: weight lookup
  logic [W_W-1:0]   w1, w2;
  logic [TOT_W-1:0] tot;
  assign w1  = WEIGHT_LUT[e1_r];
  assign w2  = WEIGHT_LUT[e2_r];
  assign tot = TOT_W'(W_EMPTY) + TOT_W'(w1) + TOT_W'(w2);

  // stage 3: scale the draw
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(s3_r.rnd) * PROD_W'(tot_r);

  // stage 4: pick the species; an update outside the lattice reports empty
  logic [1:0] s4_spc;
  always_comb begin
    priority if (!s4_r.upd || s4_r.oor) begin
      s4_spc = s4_r.spc;
    end else if (r_r < TOT_W'(W_EMPTY)) begin
      s4_spc = SPC_EMPTY;
    end else if (r_r < TOT_W'(W_EMPTY) + TOT_W'(w1_s4_r)) begin
      s4_spc = SPC_FIRST;
    end else begin
      s4_spc = SPC_SECOND;
    end
  end

  assign adv = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r         <= in_item;
      s2_r         <= s1_st;
      e1_r         <= sat8(e1_sum);
      e2_r         <= sat8(e2_sum);
      s3_r         <= s2_r;
      w1_s3_r      <= w1;
      tot_r        <= tot;
      s4_r         <= s3_r;
      w1_s4_r      <= w1_s3_r;
      r_r          <= prod[PROD_W-1:RND_W];
      out_site_r   <= s4_r.site;
      out_spc_r    <= s4_spc;
      out_status_r <= s4_r.oor;
    end
  end

  always_comb begin
    pend[0].act  = s1_vld_r && s1_r.mw;
    pend[0].site = s1_r.site;
    pend[1].act  = s2_vld_r && s2_r.mw;
    pend[1].site = s2_r.site;
    pend[2].act  = s3_vld_r && s3_r.mw;
    pend[2].site = s3_r.site;
    pend[3].act  = s4_vld_r && s4_r.mw;
    pend[3].site = s4_r.site;
  end

  assign mem_wr.en   = adv && s4_vld_r && s4_r.mw;
  assign mem_wr.site = s4_r.site;
  assign mem_wr.spc  = s4_spc;

  assign out_vld    = out_vld_r;
  assign out_site   = out_site_r;
  assign out_spc    = out_spc_r;
  assign out_status = out_status_r;

endmodule

// File: dv/lattice_gas_gibbs_site_update_test.sv
`timescale 1ns / 100ps

// Site-update checker: every transfer on the input stream is run through a
// local lattice predictor, every result transfer is compared against the
// oldest prediction.
module lattice_gas_gibbs_site_update_test;
  import lgg_pkg::*;

  localparam int LATTICE_DEPTH = 1024;

  // Codes with no package name
  localparam logic [1:0] OP_SPARE    = 2'd3;  // unused opcode, behaves as read
  localparam logic [1:0] SPC_INVALID = 2'd3;  // write value stored as empty
  localparam logic       ST_OK       = 1'b0;
  localparam logic       ST_OUTSIDE  = 1'b1;

  typedef struct packed {
    logic [10:0] site;
    logic [1:0]  spc;
    logic        status;
  } site_result_t;

  // Lattice predictor plus queue of predicted results
  class site_scoreboard;
    logic [1:0]   lattice [LATTICE_DEPTH];
    logic [7:0]   bias [2];
    logic [7:0]   coup [2][2];
    logic [10:0]  length_reg;
    int unsigned  weight_tab [256];
    site_result_t expected_q [$];
    int           fail_count;

    function new();
      longint unsigned pw [8];
      longint unsigned term, sum, p;
      int mag;
      for (int i = 0; i < LATTICE_DEPTH; i++) lattice[i] = SPC_EMPTY;
      bias[0] = '0;
      bias[1] = '0;
      for (int a = 0; a < 2; a++) begin
        coup[a][0] = '0;
        coup[a][1] = '0;
      end
      length_reg = LEN_RESET;
      fail_count = 0;
      // exp(1/16) in Q50 by series, higher powers of two by squaring
      term = 64'd1 << 50;
      sum  = term;
      for (int n = 1; n <= 20; n++) begin
        term = (term >> 4) / 64'(n);
        sum  = sum + term;
      end
      pw[0] = sum;
      for (int k = 1; k < 8; k++) pw[k] = q50_mul(pw[k-1], pw[k-1]);
      for (int e = -128; e <= 127; e++) begin
        mag = (e < 0) ? -e : e;
        p   = 64'd1 << 50;
        for (int k = 0; k < 8; k++)
          if (mag[k]) p = q50_mul(p, pw[k]);
        if (e >= 0)
          weight_tab[e+128] = 32'((p + (64'd1 << 41)) >> 42);
        else
          weight_tab[e+128] = 32'(((64'd1 << 58) + (p >> 1)) / p);
      end
    endfunction

    function longint unsigned q50_mul(longint unsigned a, longint unsigned b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[113:50];
    endfunction

    // Saturated Q4.4 energy of candidate species cand+1 at a one-based site
    function int energy(int cand, int site, int le);
      int e;
      logic [1:0] nb;
      e = int'($signed(bias[cand]));
      if (site >= 2) begin
        nb = lattice[site-2];
        if (nb == SPC_FIRST || nb == SPC_SECOND) e += $signed(coup[cand][int'(nb)-1]);
      end
      if (site + 1 <= le) begin
        nb = lattice[site];
        if (nb == SPC_FIRST || nb == SPC_SECOND) e += $signed(coup[cand][int'(nb)-1]);
      end
      if (e > 127) e = 127;
      if (e < -128) e = -128;
      return e;
    endfunction

    function void load_reg(cfg_reg_e idx, logic [10:0] val);
      case (idx)
        REG_BIAS_FIRST:     bias[0]    = val[7:0];
        REG_BIAS_SECOND:    bias[1]    = val[7:0];
        REG_COUP_FF:        coup[0][0] = val[7:0];
        REG_COUP_FS:        coup[0][1] = val[7:0];
        REG_COUP_SF:        coup[1][0] = val[7:0];
        REG_COUP_SS:        coup[1][1] = val[7:0];
        REG_LATTICE_LENGTH: length_reg = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] op, logic [10:0] site, logic [1:0] spin,
                            logic [15:0] frac);
      site_result_t    res;
      int              le;
      int unsigned     w1, w2;
      longint unsigned total, r;
      le = (length_reg > LATTICE_DEPTH) ? LATTICE_DEPTH : int'(length_reg);
      res.site   = site;
      res.status = ST_OK;
      if (site < 1 || site > le) begin
        res.spc    = SPC_EMPTY;
        res.status = ST_OUTSIDE;
      end else if (op == OP_UPDATE) begin
        w1    = weight_tab[energy(0, site, le) + 128];
        w2    = weight_tab[energy(1, site, le) + 128];
        total = 64'(W_EMPTY) + w1 + w2;
        r     = (64'(frac) * total) >> 16;
        if (r < W_EMPTY)           res.spc = SPC_EMPTY;
        else if (r < W_EMPTY + w1) res.spc = SPC_FIRST;
        else                       res.spc = SPC_SECOND;
        lattice[site-1] = res.spc;
      end else if (op == OP_WRITE) begin
        res.spc = (spin == SPC_INVALID) ? SPC_EMPTY : spin;
        lattice[site-1] = res.spc;
      end else begin
        res.spc = lattice[site-1];
      end
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [10:0] site, logic [1:0] spc, logic status);
      site_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: site %0d species %0d status %0d",
                         site, spc, status));
        return;
      end
      want = expected_q.pop_front();
      if (want.site !== site || want.spc !== spc || want.status !== status)
        report($sformatf("mismatch: expected site %0d species %0d status %0d, got %0d %0d %0d",
                         want.site, want.spc, want.status, site, spc, status));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // Every input known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [10:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;   // site_index[10:0], species_in[12:11], random_fraction[28:13]
  logic [1:0]  in_tuser   = '0;   // operation[1:0]
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;         // site_index_out[10:0], species_out[12:11]
  logic [0:0]  out_tuser;         // status[0]

  // Random idling on both streams; cleared for the closing phase
  bit idle_on     = 1'b1;
  // Set by the main sequence to make the receiver back off for a long stretch
  int hold_cycles = 0;

  site_scoreboard lattice_sb = new();

  lattice_gas_gibbs_site_update DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Result side: sample pre-edge values, every transfer goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      lattice_sb.check_result(out_tdata[10:0], out_tdata[12:11], out_tuser[0]);
  end

  // Receiver: ready in runs, random stall bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // One register write per edge; the caller drops cfg_we afterwards
  task automatic write_reg(cfg_reg_e idx, logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    lattice_sb.load_reg(idx, val);
    @(posedge clk);
  endtask

  // Full register set; upper data bits of the 8-bit registers are don't-care
  task automatic apply_settings(logic [7:0] b1, logic [7:0] b2, logic [7:0] ff,
                                logic [7:0] fs, logic [7:0] sf, logic [7:0] ss,
                                logic [10:0] len);
    write_reg(REG_BIAS_FIRST,     {3'($urandom), b1});
    write_reg(REG_BIAS_SECOND,    {3'($urandom), b2});
    write_reg(REG_COUP_FF,        {3'($urandom), ff});
    write_reg(REG_COUP_FS,        {3'($urandom), fs});
    write_reg(REG_COUP_SF,        {3'($urandom), sf});
    write_reg(REG_COUP_SS,        {3'($urandom), ss});
    write_reg(REG_LATTICE_LENGTH, len);
    cfg_we <= 1'b0;
  endtask

  // Offer one item, hold it until the transfer, then log it with the predictor.
  // tvalid stays high into the next call unless a gap is inserted.
  task automatic send_item(logic [1:0] op, logic [10:0] site, logic [1:0] spin,
                           logic [15:0] frac);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, frac, spin, site};
    do @(posedge clk); while (!in_tready);
    lattice_sb.note_item(op, site, spin, frac);
  endtask

  // Drain: all results back, then a wait for the last lattice write
  task automatic settle();
    in_tvalid <= 1'b0;
    while (lattice_sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Random phase. Sites mostly come from a 16-site window that moves now and
  // then, so updates see occupied neighbours; a slice goes outside the lattice.
  task automatic run_phase(int count, logic [10:0] len, int style);
    logic [7:0]  v [6];
    logic [1:0]  op;
    logic [10:0] s;
    logic [15:0] frac;
    int          le, base, hi, pick;
    for (int i = 0; i < 6; i++) begin
      case (style)
        0:       v[i] = 8'($urandom);
        1:       v[i] = 8'h7F;
        2:       v[i] = 8'h80;
        3: begin
          pick = $urandom_range(0, 2);
          v[i] = (pick == 0) ? 8'h80 : (pick == 1) ? 8'h7F : 8'h00;
        end
        default: v[i] = 8'($urandom_range(0, 64) - 32);
      endcase
    end
    apply_settings(v[0], v[1], v[2], v[3], v[4], v[5], len);
    le   = (len > LATTICE_DEPTH) ? LATTICE_DEPTH : int'(len);
    base = 1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (le == 0 || pick < 8) begin
        s = 11'($urandom_range(0, 2047));
      end else if (pick < 12) begin
        s = (pick < 10) ? 11'd0 : 11'(le + 1);
      end else begin
        if ($urandom_range(0, 31) == 0) base = $urandom_range(1, le);
        hi = (base + 15 > le) ? le : base + 15;
        s  = 11'($urandom_range(base, hi));
      end
      pick = $urandom_range(0, 99);
      op   = (pick < 50) ? OP_UPDATE : (pick < 75) ? OP_WRITE :
             (pick < 95) ? OP_READ : OP_SPARE;
      pick = $urandom_range(0, 99);
      frac = (pick < 5) ? 16'h0000 : (pick < 10) ? 16'hFFFF : 16'($urandom);
      send_item(op, s, 2'($urandom_range(0, 3)), frac);
    end
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: writes incl. value 3, spare opcode, draw extremes, lattice ends,
    // sites 0 and beyond the length. First items wait out the clearing pass.
    apply_settings(8'h10, 8'hF0, 8'h7F, 8'h80, 8'h20, 8'hE0, LEN_RESET);
    send_item(OP_WRITE,  11'd1,    SPC_FIRST,   16'h1234);
    send_item(OP_WRITE,  11'd2,    SPC_SECOND,  16'h0000);
    send_item(OP_WRITE,  11'd3,    SPC_INVALID, 16'hFFFF);
    send_item(OP_READ,   11'd3,    SPC_EMPTY,   16'h0000);
    send_item(OP_SPARE,  11'd2,    SPC_FIRST,   16'h0000);
    send_item(OP_UPDATE, 11'd2,    SPC_EMPTY,   16'h0000);
    send_item(OP_UPDATE, 11'd2,    SPC_EMPTY,   16'hFFFF);
    send_item(OP_READ,   11'd0,    SPC_EMPTY,   16'h0000);
    send_item(OP_UPDATE, 11'd1025, SPC_EMPTY,   16'h8000);
    send_item(OP_WRITE,  11'd2047, SPC_SECOND,  16'hFFFF);
    send_item(OP_WRITE,  11'd1024, SPC_SECOND,  16'h0000);
    send_item(OP_UPDATE, 11'd1024, SPC_EMPTY,   16'hFFFF);
    send_item(OP_UPDATE, 11'd1023, SPC_EMPTY,   16'h9C40);
    send_item(OP_UPDATE, 11'd1,    SPC_EMPTY,   16'h7530);
    send_item(OP_WRITE,  11'd10,   SPC_FIRST,   16'h0000);
    settle();

    // Shrunk lattice: site 10 now outside, site 5 has no right neighbour
    apply_settings(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 11'd5);
    send_item(OP_READ,   11'd10, SPC_EMPTY,  16'h0000);
    send_item(OP_UPDATE, 11'd5,  SPC_EMPTY,  16'hFFFF);
    send_item(OP_UPDATE, 11'd4,  SPC_EMPTY,  16'h8000);
    send_item(OP_WRITE,  11'd6,  SPC_FIRST,  16'h0000);
    settle();

    // Zero length: every site outside
    apply_settings(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 11'd0);
    send_item(OP_READ,   11'd1, SPC_EMPTY, 16'h0000);
    send_item(OP_UPDATE, 11'd1, SPC_EMPTY, 16'hFFFF);
    settle();

    // Length above the depth saturates; site 10 kept its content
    apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 11'd2047);
    send_item(OP_READ,   11'd10,   SPC_EMPTY, 16'h0000);
    send_item(OP_READ,   11'd1024, SPC_EMPTY, 16'h0000);
    send_item(OP_UPDATE, 11'd1023, SPC_EMPTY, 16'hFFFF);
    settle();

    // Random phases; the first one runs against a long receiver hold-off
    hold_cycles = 250;
    run_phase(200, 11'd16,   0);
    run_phase(60,  11'd1,    3);
    run_phase(80,  11'd2,    1);
    run_phase(200, 11'd1024, 0);
    run_phase(150, 11'd2047, 2);
    run_phase(30,  11'd0,    0);
    run_phase(200, 11'd7,    3);
    run_phase(200, 11'd33,   4);
    run_phase(200, 11'd12,   0);
    idle_on = 1'b0;
    run_phase(280, 11'd24,   0);

    if (lattice_sb.fail_count == 0 && lattice_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/lgg_pkg.sv
rtl/core/lgg_site_mem.sv
rtl/core/lgg_update_pipe.sv
rtl/core/lattice_gas_gibbs_site_update.sv
dv/lattice_gas_gibbs_site_update_test.sv
